/* rtl/cnfl_pkg.sv */
package cnfl_pkg;

  // Pool geometry
  localparam int unsigned NUM_CHUNKS      = 16;
  localparam int unsigned NODES_PER_CHUNK = 255;
  localparam int unsigned HEADER_BYTES    = 16;
  localparam int unsigned CHUNK_ALIGN     = 16;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned NSIZE_W  = 16;
  localparam int unsigned ND_W     = $clog2(NODES_PER_CHUNK + 1);
  localparam int unsigned CH_W     = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned CIDX_W   = $clog2(NUM_CHUNKS + 1);
  localparam int unsigned FREE_W   = 12;
  localparam int unsigned STRIDE_MAX =
    HEADER_BYTES + ((1 << NSIZE_W) - 1) * NODES_PER_CHUNK + CHUNK_ALIGN;
  localparam int unsigned STRIDE_W = $clog2(STRIDE_MAX + 1);
  localparam int unsigned MEM_DEPTH = NUM_CHUNKS * (1 << ND_W);

  // Status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_EMPTY    = 3'd1;
  localparam logic [2:0] STAT_FOREIGN  = 3'd2;
  localparam logic [2:0] STAT_MISALIGN = 3'd3;
  localparam logic [2:0] STAT_DOUBLE   = 3'd4;

  // Operations
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Register indexes
  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_BYTES  = 2'd1;
  localparam logic [1:0] CFG_NBYTES = 2'd2;

  localparam logic [NSIZE_W-1:0] NBYTES_RST = 16'd8;

endpackage

/* rtl/cnfl_div.sv */
module cnfl_div import cnfl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DATA_W-1:0]   dividend_i,
  input  logic [STRIDE_W-1:0] divisor_i,
  output logic                done_o,
  output logic [DATA_W-1:0]   quot_o,
  output logic [STRIDE_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W + 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DATA_W-1:0]   quo_q, quo_d;
  logic [STRIDE_W-1:0] rem_q, rem_d;
  logic [STRIDE_W-1:0] dvs_q, dvs_d;
  logic [STRIDE_W:0]   r_sh;
  logic [STRIDE_W:0]   r_sub;
  logic                ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    r_sh   = {rem_q, quo_q[DATA_W-1]};
    ge     = r_sh >= {1'b0, dvs_q};
    r_sub  = r_sh - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DATA_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DATA_W-2:0], ge};
      rem_d = ge ? r_sub[STRIDE_W-1:0] : r_sh[STRIDE_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/chunked_node_free_list_unit.sv */
// Allocate: chunk search in S_PICK (one ring position a cycle), then S_ALOC_RD, S_ALOC_WR
// and S_FIN; an empty pool goes straight to S_FIN.
// Release: two passes of the shared divider and the free-list walk through the link memory;
// errors end it sooner.
// One item at a time; the result register lets the next item in while a result waits.
// Reset and each register write rerun the pool setup, input held off.
module chunked_node_free_list_unit import cnfl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration writes
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [DATA_W-1:0] cfg_data_i,
  // requests
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [31:0]       s_axis_tdata,  // [31:0] address
  input  logic              s_axis_tuser,  // [0] op
  // results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,  // [31:0] node_address, [43:32] free_total
  output logic [2:0]        m_axis_tuser   // [2:0] status
);

  localparam int unsigned CS_W = CH_W + STRIDE_W;
  localparam int unsigned NN_W = ND_W + NSIZE_W;
  localparam int unsigned AD_W = CH_W + ND_W;

  localparam logic [4:0] S_INIT_A   = 5'd0;
  localparam logic [4:0] S_INIT_RND = 5'd1;
  localparam logic [4:0] S_INIT_B   = 5'd2;
  localparam logic [4:0] S_INIT_D1  = 5'd3;
  localparam logic [4:0] S_INIT_D2  = 5'd4;
  localparam logic [4:0] S_INIT_SET = 5'd5;
  localparam logic [4:0] S_IDLE     = 5'd6;
  localparam logic [4:0] S_PICK     = 5'd7;
  localparam logic [4:0] S_ALOC_RD  = 5'd8;
  localparam logic [4:0] S_ALOC_WR  = 5'd9;
  localparam logic [4:0] S_RDIV     = 5'd10;
  localparam logic [4:0] S_RCHK     = 5'd11;
  localparam logic [4:0] S_RDIV2    = 5'd12;
  localparam logic [4:0] S_WALK     = 5'd13;
  localparam logic [4:0] S_WALK_RD  = 5'd14;
  localparam logic [4:0] S_RWR      = 5'd15;
  localparam logic [4:0] S_FIN      = 5'd16;

  localparam logic [1:0] PK_AMARK = 2'd0;
  localparam logic [1:0] PK_RMARK = 2'd1;
  localparam logic [1:0] PK_RING  = 2'd2;

  logic [4:0]          state_q, state_d;
  logic [DATA_W-1:0]   base_q, base_d, rbytes_q, rbytes_d;
  logic [NSIZE_W-1:0]  nbytes_q, nbytes_d, nsize_q, nsize_d;
  logic [STRIDE_W-1:0] stride_q, stride_d;
  logic [DATA_W-1:0]   full_q, full_d;
  logic                part_q, part_d;
  logic [ND_W-1:0]     extra_q, extra_d;

  logic [ND_W-1:0]     cnodes_q [NUM_CHUNKS];
  logic [ND_W-1:0]     cnodes_d [NUM_CHUNKS];
  logic [ND_W-1:0]     cfree_q  [NUM_CHUNKS];
  logic [ND_W-1:0]     cfree_d  [NUM_CHUNKS];
  logic [ND_W-1:0]     head_q   [NUM_CHUNKS];
  logic [ND_W-1:0]     head_d   [NUM_CHUNKS];
  logic [ND_W-1:0]     fill_q   [NUM_CHUNKS];
  logic [ND_W-1:0]     fill_d   [NUM_CHUNKS];

  logic [CIDX_W-1:0]   count_q, count_d;
  logic [FREE_W-1:0]   free_q, free_d;
  logic [CIDX_W-1:0]   amark_q, amark_d, rmark_q, rmark_d;
  logic [CH_W-1:0]     sel_q, sel_d;
  logic [1:0]          pk_q, pk_d;
  logic                side_q, side_d;
  logic [CIDX_W-1:0]   fwd_q, fwd_d, bwd_q, bwd_d;
  logic [7:0]          k_q, k_d;
  logic [ND_W-1:0]     idx_q, idx_d, cur_q, cur_d, mi_q, mi_d;
  logic [STRIDE_W-1:0] rel_q, rel_d;
  logic [NN_W-1:0]     lim_q, lim_d, nn_q, nn_d;
  logic [CS_W-1:0]     cs_q, cs_d;
  logic [DATA_W-1:0]   res_addr_q, res_addr_d;
  logic [2:0]          res_stat_q, res_stat_d;
  logic                m_valid_q, m_valid_d;
  logic [DATA_W-1:0]   m_addr_q, m_addr_d;
  logic [2:0]          m_stat_q, m_stat_d;
  logic [FREE_W-1:0]   m_free_q, m_free_d;

  // link memory
  logic [ND_W-1:0]     link_mem [MEM_DEPTH];
  logic [ND_W-1:0]     mem_rdata_q;
  logic [AD_W-1:0]     mem_raddr, mem_waddr;
  logic [ND_W-1:0]     mem_wdata;
  logic                mem_we;

  // shared divider
  logic                div_start, div_done;
  logic [DATA_W-1:0]   div_dividend, div_quot;
  logic [STRIDE_W-1:0] div_divisor, div_rem;

  logic [CIDX_W-1:0]   pos, a_pos, fullc;
  logic                pos_free, pe;
  logic [NSIZE_W-1:0]  ns;
  logic [ND_W-1:0]     node, midx, link_val;

  cnfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    // defaults: hold
    state_d = state_q;
    base_d = base_q; rbytes_d = rbytes_q; nbytes_d = nbytes_q;
    nsize_d = nsize_q; stride_d = stride_q; full_d = full_q;
    part_d = part_q; extra_d = extra_q;
    cnodes_d = cnodes_q; cfree_d = cfree_q; head_d = head_q; fill_d = fill_q;
    count_d = count_q; free_d = free_q; amark_d = amark_q; rmark_d = rmark_q;
    sel_d = sel_q; pk_d = pk_q; side_d = side_q;
    fwd_d = fwd_q; bwd_d = bwd_q; k_d = k_q;
    idx_d = idx_q; cur_d = cur_q; mi_d = mi_q;
    rel_d = rel_q; lim_d = lim_q; nn_d = nn_q; cs_d = cs_q;
    res_addr_d = res_addr_q; res_stat_d = res_stat_q;
    m_valid_d = m_valid_q; m_addr_d = m_addr_q; m_stat_d = m_stat_q; m_free_d = m_free_q;
    mem_raddr = '0; mem_waddr = '0; mem_wdata = '0; mem_we = 1'b0;
    div_start = 1'b0; div_dividend = '0; div_divisor = '0;

    ns = (nbytes_q == '0) ? NSIZE_W'(1) : nbytes_q;

    // chunk probe for the search
    case (pk_q)
      PK_AMARK: pos = amark_q;
      PK_RMARK: pos = rmark_q;
      default:  pos = side_q ? bwd_q : fwd_q;
    endcase
    pos_free = (pos < count_q) && (cfree_q[pos[CH_W-1:0]] != '0);
    a_pos    = (amark_q < count_q) ? amark_q : count_q;

    node     = head_q[sel_q];
    midx     = (node == ND_W'(NODES_PER_CHUNK)) ? '0 : node;
    link_val = (mi_q >= fill_q[sel_q]) ? mi_q + 1'b1 : mem_rdata_q;

    fullc = (full_q >= DATA_W'(NUM_CHUNKS)) ? CIDX_W'(NUM_CHUNKS) : full_q[CIDX_W-1:0];
    pe    = (full_q < DATA_W'(NUM_CHUNKS)) && part_q;

    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    case (state_q)
      // node size and raw stride, then round up to the chunk alignment
      S_INIT_A: begin
        nsize_d  = ns;
        stride_d = STRIDE_W'(HEADER_BYTES) + STRIDE_W'(ns) * STRIDE_W'(NODES_PER_CHUNK);
        state_d  = S_INIT_RND;
      end
      S_INIT_RND: begin
        stride_d = stride_q
                   + STRIDE_W'((CHUNK_ALIGN - stride_q % CHUNK_ALIGN) % CHUNK_ALIGN);
        state_d  = S_INIT_B;
      end
      S_INIT_B: begin
        div_start    = 1'b1;
        div_dividend = rbytes_q;
        div_divisor  = stride_q;
        state_d      = S_INIT_D1;
      end
      // full chunks and the remainder
      S_INIT_D1: begin
        if (div_done) begin
          full_d  = div_quot;
          part_d  = DATA_W'(div_rem) >= DATA_W'(HEADER_BYTES) + DATA_W'(nsize_q);
          extra_d = '0;
          if (DATA_W'(div_rem) >= DATA_W'(HEADER_BYTES) + DATA_W'(nsize_q)) begin
            div_start    = 1'b1;
            div_dividend = DATA_W'(div_rem) - DATA_W'(HEADER_BYTES);
            div_divisor  = STRIDE_W'(nsize_q);
            state_d      = S_INIT_D2;
          end else begin
            state_d = S_INIT_SET;
          end
        end
      end
      S_INIT_D2: begin
        if (div_done) begin
          extra_d = (div_quot > DATA_W'(NODES_PER_CHUNK)) ? ND_W'(NODES_PER_CHUNK)
                                                          : div_quot[ND_W-1:0];
          state_d = S_INIT_SET;
        end
      end
      // per-chunk counts, lists back to their initial order
      S_INIT_SET: begin
        for (int c = 0; c < NUM_CHUNKS; c++) begin
          if (DATA_W'(c) < full_q) cnodes_d[c] = ND_W'(NODES_PER_CHUNK);
          else if (DATA_W'(c) == full_q && part_q) cnodes_d[c] = extra_q;
          else cnodes_d[c] = '0;
          cfree_d[c] = cnodes_d[c];
          head_d[c]  = '0;
          fill_d[c]  = '0;
        end
        count_d = fullc + CIDX_W'(pe);
        free_d  = FREE_W'(fullc) * FREE_W'(NODES_PER_CHUNK) + FREE_W'(pe ? extra_q : '0);
        amark_d = CIDX_W'(NUM_CHUNKS);
        rmark_d = CIDX_W'(NUM_CHUNKS);
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          res_addr_d = '0;
          res_stat_d = STAT_OK;
          if (s_axis_tuser == OP_ALLOC) begin
            if (free_q == '0) begin
              res_stat_d = STAT_EMPTY;
              state_d    = S_FIN;
            end else begin
              pk_d    = PK_AMARK;
              side_d  = 1'b0;
              k_d     = '0;
              state_d = S_PICK;
            end
          end else if (s_axis_tdata < base_q) begin
            res_stat_d = STAT_FOREIGN;
            state_d    = S_FIN;
          end else begin
            div_start    = 1'b1;
            div_dividend = s_axis_tdata - base_q;
            div_divisor  = stride_q;
            state_d      = S_RDIV;
          end
        end
      end
      // one ring position a cycle: markers first, then forward and backward in turn
      S_PICK: begin
        if (pos_free) begin
          sel_d   = pos[CH_W-1:0];
          state_d = S_ALOC_RD;
        end else begin
          case (pk_q)
            PK_AMARK: pk_d = PK_RMARK;
            PK_RMARK: begin
              pk_d   = PK_RING;
              side_d = 1'b0;
              fwd_d  = (a_pos == count_q) ? '0 : a_pos + 1'b1;
              bwd_d  = (a_pos == '0) ? count_q : a_pos - 1'b1;
            end
            default: begin
              if (!side_q) begin
                side_d = 1'b1;
              end else begin
                side_d = 1'b0;
                k_d    = k_q + 1'b1;
                fwd_d  = (fwd_q == count_q) ? '0 : fwd_q + 1'b1;
                bwd_d  = (bwd_q == '0) ? count_q : bwd_q - 1'b1;
                if (k_q == 8'(count_q)) begin
                  res_stat_d = STAT_EMPTY;
                  state_d    = S_FIN;
                end
              end
            end
          endcase
        end
      end
      S_ALOC_RD: begin
        mem_raddr = {sel_q, midx};
        mi_d      = midx;
        idx_d     = node;
        cs_d      = CS_W'(sel_q) * CS_W'(stride_q);
        nn_d      = NN_W'(node) * NN_W'(nsize_q);
        state_d   = S_ALOC_WR;
      end
      // pop the head
      S_ALOC_WR: begin
        head_d[sel_q]  = link_val;
        cfree_d[sel_q] = cfree_q[sel_q] - 1'b1;
        free_d         = free_q - 1'b1;
        if (mi_q == fill_q[sel_q]) fill_d[sel_q] = fill_q[sel_q] + 1'b1;
        amark_d    = CIDX_W'(sel_q);
        res_addr_d = base_q + DATA_W'(cs_q) + DATA_W'(HEADER_BYTES) + DATA_W'(nn_q);
        state_d    = S_FIN;
      end
      // chunk and offset within it
      S_RDIV: begin
        if (div_done) begin
          sel_d = div_quot[CH_W-1:0];
          rel_d = div_rem - STRIDE_W'(HEADER_BYTES);
          lim_d = NN_W'(cnodes_q[div_quot[CH_W-1:0]]) * NN_W'(nsize_q);
          if (div_quot >= DATA_W'(count_q) || div_rem < STRIDE_W'(HEADER_BYTES)) begin
            res_stat_d = STAT_FOREIGN;
            state_d    = S_FIN;
          end else begin
            state_d = S_RCHK;
          end
        end
      end
      S_RCHK: begin
        if (DATA_W'(rel_q) >= DATA_W'(lim_q)) begin
          res_stat_d = STAT_FOREIGN;
          state_d    = S_FIN;
        end else begin
          rmark_d      = CIDX_W'(sel_q);
          div_start    = 1'b1;
          div_dividend = DATA_W'(rel_q);
          div_divisor  = STRIDE_W'(nsize_q);
          state_d      = S_RDIV2;
        end
      end
      S_RDIV2: begin
        if (div_done) begin
          if (div_rem != '0) begin
            res_stat_d = STAT_MISALIGN;
            state_d    = S_FIN;
          end else begin
            idx_d   = div_quot[ND_W-1:0];
            cur_d   = head_q[sel_q];
            k_d     = '0;
            state_d = S_WALK;
          end
        end
      end
      // double-free walk over the chunk's free list
      S_WALK: begin
        if (k_q == 8'(cfree_q[sel_q])) begin
          state_d = S_RWR;
        end else if (cur_q == idx_q) begin
          res_stat_d = STAT_DOUBLE;
          state_d    = S_FIN;
        end else begin
          mi_d      = (cur_q == ND_W'(NODES_PER_CHUNK)) ? '0 : cur_q;
          mem_raddr = {sel_q, mi_d};
          k_d       = k_q + 1'b1;
          state_d   = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        cur_d   = link_val;
        state_d = S_WALK;
      end
      // push the node
      S_RWR: begin
        mem_we         = 1'b1;
        mem_waddr      = {sel_q, idx_q};
        mem_wdata      = head_q[sel_q];
        head_d[sel_q]  = idx_q;
        cfree_d[sel_q] = cfree_q[sel_q] + 1'b1;
        free_d         = free_q + 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_addr_d  = res_addr_q;
          m_stat_d  = res_stat_q;
          m_free_d  = free_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_INIT_A;
    endcase

    // register write restarts the pool setup
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BASE:   begin base_d   = cfg_data_i;                 state_d = S_INIT_A; end
        CFG_BYTES:  begin rbytes_d = cfg_data_i;                 state_d = S_INIT_A; end
        CFG_NBYTES: begin nbytes_d = cfg_data_i[NSIZE_W-1:0];    state_d = S_INIT_A; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT_A;
      base_q    <= '0;
      rbytes_q  <= '0;
      nbytes_q  <= NBYTES_RST;
      count_q   <= '0;
      free_q    <= '0;
      amark_q   <= CIDX_W'(NUM_CHUNKS);
      rmark_q   <= CIDX_W'(NUM_CHUNKS);
      pk_q      <= PK_AMARK;
      side_q    <= 1'b0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CHUNKS; c++) begin
        cfree_q[c] <= '0;
        head_q[c]  <= '0;
        fill_q[c]  <= '0;
      end
    end else begin
      state_q   <= state_d;
      base_q    <= base_d;
      rbytes_q  <= rbytes_d;
      nbytes_q  <= nbytes_d;
      count_q   <= count_d;
      free_q    <= free_d;
      amark_q   <= amark_d;
      rmark_q   <= rmark_d;
      pk_q      <= pk_d;
      side_q    <= side_d;
      k_q       <= k_d;
      m_valid_q <= m_valid_d;
      cfree_q   <= cfree_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    nsize_q    <= nsize_d;
    stride_q   <= stride_d;
    full_q     <= full_d;
    part_q     <= part_d;
    extra_q    <= extra_d;
    cnodes_q   <= cnodes_d;
    sel_q      <= sel_d;
    fwd_q      <= fwd_d;
    bwd_q      <= bwd_d;
    idx_q      <= idx_d;
    cur_q      <= cur_d;
    mi_q       <= mi_d;
    rel_q      <= rel_d;
    lim_q      <= lim_d;
    nn_q       <= nn_d;
    cs_q       <= cs_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
    m_addr_q   <= m_addr_d;
    m_stat_q   <= m_stat_d;
    m_free_q   <= m_free_d;
  end

  // link memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= link_mem[mem_raddr];
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0, m_free_q, m_addr_q};
  assign m_axis_tuser  = m_stat_q;

endmodule
